// ===== rtl/segment_aabb_slab_test_defines.svh =====
// assertion helpers used by the rtl (included by segment_aabb_slab_test.sv)
`ifndef SEGMENT_AABB_SLAB_TEST_DEFINES_SVH
`define SEGMENT_AABB_SLAB_TEST_DEFINES_SVH

// checked on every clock edge outside reset
`define SABT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define SABT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/sabt_pkg.sv =====
`default_nettype none
package sabt_pkg;

  // default geometry
  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned PARAM_FRAC_DEF = 30;

  // integer bits of the slab parameter
  localparam int unsigned T_INT_BITS     = 17;
  // entry output format
  localparam int unsigned ENTRY_OUT_FRAC = 30;
  localparam int unsigned ENTRY_OUT_BITS = 31;
  // parallel limit register
  localparam int unsigned LIMIT_BITS     = 16;
  localparam int unsigned N_AXES         = 3;

  // per-parameter control carried along the divider
  typedef struct packed {
    logic par;   // direction at or below the parallel limit
    logic sat;   // integer quotient out of range
    logic neg;   // distance and direction differ in sign
    logic dpos;  // distance above zero
    logic dneg;  // distance below zero
  } slab_flags_t;

endpackage
`default_nettype wire

// ===== rtl/segment_aabb_slab_test.sv =====
// Segment against axis-aligned box test by the slab method, signed Q16.16
// coordinates in, hit flag, contact point and clamped entry parameter out.
// One beat is taken every cycle while the output is not stalled; a result
// is offered through NB + 9 register stages, with NB = 17 + PARAM_FRAC_BITS.
// The six slab dividers resolve one quotient bit per register stage.
// Each stage holds its own valid bit, so a stall on the output only backs
// up stages that are full. parallel_limit is written through
// cfg_we_i/cfg_wdata_i; the user must write it only while no beat is in
// flight, as the block itself does not enforce this.
`default_nettype none
`include "segment_aabb_slab_test_defines.svh"
module segment_aabb_slab_test #(
  parameter int unsigned COORD_BITS      = sabt_pkg::COORD_BITS_DEF,
  parameter int unsigned PARAM_FRAC_BITS = sabt_pkg::PARAM_FRAC_DEF
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      cfg_we_i,
  input  wire logic [sabt_pkg::LIMIT_BITS-1:0]           cfg_wdata_i,
  input  wire logic                                      s_axis_tvalid,
  output logic                                           s_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  wire logic [((12*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                           m_axis_tvalid,
  input  wire logic                                      m_axis_tready,
  // hit, hit_x, hit_y, hit_z, entry_param
  output logic [((3*COORD_BITS+32+7)/8)*8-1:0]           m_axis_tdata
);
  import sabt_pkg::*;

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned F     = PARAM_FRAC_BITS;
  localparam int unsigned D     = C + 1;
  localparam int unsigned NB    = T_INT_BITS + F;
  localparam int unsigned TW    = NB + 1;
  localparam int unsigned L     = NB + 3;
  localparam int unsigned NST   = L + 6;
  localparam int unsigned EW    = F + 1;
  localparam int unsigned PW    = D + EW;
  localparam int unsigned OUT_W = ((3*C+32+7)/8)*8;
  localparam int unsigned K_MM  = L + 1;
  localparam int unsigned K_RD  = L + 2;
  localparam int unsigned K_HT  = L + 3;
  localparam int unsigned K_ML  = L + 4;
  localparam int unsigned K_OUT = L + 5;
  localparam logic [TW-1:0] T_ONE = {{(TW-F-1){1'b0}}, 1'b1, {F{1'b0}}};

  // stage valid bits and back-pressure
  logic [NST-1:0] v_q, rdy, vin;

  always_comb begin
    rdy[NST-1] = !v_q[NST-1] || m_axis_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign vin = {v_q[NST-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (v_q & ~rdy) | (vin & rdy);
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v_q[NST-1];

  // parallel limit register
  logic [LIMIT_BITS-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // input stage: direction and slab distances
  logic [C-1:0] s0_q  [N_AXES];
  logic [D-1:0] d0_q  [N_AXES];
  logic [D-1:0] dlo_q [N_AXES];
  logic [D-1:0] dhi_q [N_AXES];

  for (genvar a = 0; a < N_AXES; a++) begin : g_in
    logic [C-1:0] fs, fe, fl, fh;
    assign fs = s_axis_tdata[a*C +: C];
    assign fe = s_axis_tdata[(3+a)*C +: C];
    assign fl = s_axis_tdata[(6+a)*C +: C];
    assign fh = s_axis_tdata[(9+a)*C +: C];
    always_ff @(posedge clk_i) begin
      if (rdy[0]) begin
        s0_q[a]  <= fs;
        d0_q[a]  <= {fe[C-1], fe} - {fs[C-1], fs};
        dlo_q[a] <= {fl[C-1], fl} - {fs[C-1], fs};
        dhi_q[a] <= {fh[C-1], fh} - {fs[C-1], fs};
      end
    end
  end

  // slab parameters, two dividers per axis
  logic signed [TW-1:0] t_lo [N_AXES];
  logic signed [TW-1:0] t_hi [N_AXES];

  for (genvar a = 0; a < N_AXES; a++) begin : g_slab
    sabt_slab #(
      .COORD_BITS      (C),
      .PARAM_FRAC_BITS (F)
    ) u_lo (
      .clk_i   (clk_i),
      .ld_i    (rdy[L:1]),
      .dist_i  ($signed(dlo_q[a])),
      .dir_i   ($signed(d0_q[a])),
      .limit_i (limit_q),
      .t_o     (t_lo[a])
    );
    sabt_slab #(
      .COORD_BITS      (C),
      .PARAM_FRAC_BITS (F)
    ) u_hi (
      .clk_i   (clk_i),
      .ld_i    (rdy[L:1]),
      .dist_i  ($signed(dhi_q[a])),
      .dir_i   ($signed(d0_q[a])),
      .limit_i (limit_q),
      .t_o     (t_hi[a])
    );
  end

  // start point and direction magnitude ride alongside the dividers
  logic [C-1:0] sb_s_q  [1:K_HT][N_AXES];
  logic [D-1:0] sb_dm_q [1:K_HT][N_AXES];
  logic         sb_dn_q [1:K_HT][N_AXES];

  for (genvar a = 0; a < N_AXES; a++) begin : g_sb
    always_ff @(posedge clk_i) begin
      if (rdy[1]) begin
        sb_s_q[1][a]  <= s0_q[a];
        sb_dm_q[1][a] <= d0_q[a][D-1] ? -d0_q[a] : d0_q[a];
        sb_dn_q[1][a] <= d0_q[a][D-1];
      end
    end
    for (genvar k = 2; k <= K_HT; k++) begin : g_k
      always_ff @(posedge clk_i) begin
        if (rdy[k]) begin
          sb_s_q[k][a]  <= sb_s_q[k-1][a];
          sb_dm_q[k][a] <= sb_dm_q[k-1][a];
          sb_dn_q[k][a] <= sb_dn_q[k-1][a];
        end
      end
    end
  end

  // per-axis ordering of the two parameters
  logic signed [TW-1:0] mn_q [N_AXES];
  logic signed [TW-1:0] mx_q [N_AXES];

  for (genvar a = 0; a < N_AXES; a++) begin : g_mm
    always_ff @(posedge clk_i) begin
      if (rdy[K_MM]) begin
        mn_q[a] <= (t_lo[a] < t_hi[a]) ? t_lo[a] : t_hi[a];
        mx_q[a] <= (t_lo[a] < t_hi[a]) ? t_hi[a] : t_lo[a];
      end
    end
  end

  // entry is the latest minimum, exit the earliest maximum
  logic signed [TW-1:0] en_d, ex_d, en_q, ex_q;

  always_comb begin
    en_d = mn_q[0];
    ex_d = mx_q[0];
    for (int a = 1; a < N_AXES; a++) begin
      if (mn_q[a] > en_d) en_d = mn_q[a];
      if (mx_q[a] < ex_d) ex_d = mx_q[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[K_RD]) begin
      en_q <= en_d;
      ex_q <= ex_d;
    end
  end

  // hit decision and clamp of the entry value
  logic          hit_d, ht_hit_q;
  logic [EW-1:0] ht_e_q;

  assign hit_d = !(ex_q < 0 || en_q > ex_q || en_q > $signed(T_ONE));

  always_ff @(posedge clk_i) begin
    if (rdy[K_HT]) begin
      ht_hit_q <= hit_d;
      ht_e_q   <= (hit_d && !en_q[TW-1]) ? en_q[F:0] : '0;
    end
  end

  // direction times entry
  logic [PW-1:0] prod_q [N_AXES];
  logic [C-1:0]  ml_s_q [N_AXES];
  logic          ml_dn_q [N_AXES];
  logic          ml_hit_q;
  logic [EW-1:0] ml_e_q;

  always_ff @(posedge clk_i) begin
    if (rdy[K_ML]) begin
      ml_hit_q <= ht_hit_q;
      ml_e_q   <= ht_e_q;
    end
  end

  for (genvar a = 0; a < N_AXES; a++) begin : g_ml
    always_ff @(posedge clk_i) begin
      if (rdy[K_ML]) begin
        prod_q[a]  <= PW'(sb_dm_q[K_HT][a]) * PW'(ht_e_q);
        ml_s_q[a]  <= sb_s_q[K_HT][a];
        ml_dn_q[a] <= sb_dn_q[K_HT][a];
      end
    end
  end

  // contact point with floor rounding, output register
  logic                      o_hit_q;
  logic [C-1:0]              o_pt_q [N_AXES];
  logic [ENTRY_OUT_BITS-1:0] o_eo_q;
  logic [EW+ENTRY_OUT_FRAC-1:0] eo_wide;

  assign eo_wide = {ml_e_q, {ENTRY_OUT_FRAC{1'b0}}} >> F;

  always_ff @(posedge clk_i) begin
    if (rdy[K_OUT]) begin
      o_hit_q <= ml_hit_q;
      o_eo_q  <= eo_wide[ENTRY_OUT_BITS-1:0];
    end
  end

  for (genvar a = 0; a < N_AXES; a++) begin : g_out
    logic [C+2:0] sx, qx, rx, pt;
    always_comb begin
      sx = {{3{ml_s_q[a][C-1]}}, ml_s_q[a]};
      qx = (C+3)'(prod_q[a][PW-1:F]);
      rx = (C+3)'(|prod_q[a][F-1:0]);
      pt = ml_dn_q[a] ? (sx - qx - rx) : (sx + qx);
    end
    always_ff @(posedge clk_i) begin
      if (rdy[K_OUT]) begin
        o_pt_q[a] <= ml_hit_q ? pt[C-1:0] : '0;
      end
    end
  end

  assign m_axis_tdata = OUT_W'({o_eo_q, o_pt_q[2], o_pt_q[1], o_pt_q[0], o_hit_q});

  // checks
  `SABT_ASSERT(a_miss_zero, m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[OUT_W-1:1] == '0, "miss beat carries a non-zero payload")
  `SABT_ASSERT(a_entry_range, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[3*C+31:3*C+1] <= 31'h4000_0000, "entry parameter above one on a hit")
  `SABT_ASSERT(a_empty_ready, $countones(v_q) == 0 |-> s_axis_tready, "empty pipeline refuses input")
  `SABT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid, "output valid straight after reset")

endmodule
`default_nettype wire

// ===== rtl/sabt_slab.sv =====
`default_nettype none
module sabt_slab #(
  parameter int unsigned COORD_BITS      = sabt_pkg::COORD_BITS_DEF,
  parameter int unsigned PARAM_FRAC_BITS = sabt_pkg::PARAM_FRAC_DEF
) (
  input  wire logic                                                clk_i,
  // stage load strobes, one per register stage
  input  wire logic [sabt_pkg::T_INT_BITS+PARAM_FRAC_BITS+2:0]     ld_i,
  input  wire logic signed [COORD_BITS:0]                          dist_i,
  input  wire logic signed [COORD_BITS:0]                          dir_i,
  input  wire logic [sabt_pkg::LIMIT_BITS-1:0]                     limit_i,
  output logic signed [sabt_pkg::T_INT_BITS+PARAM_FRAC_BITS:0]     t_o
);
  import sabt_pkg::*;

  localparam int unsigned D  = COORD_BITS + 1;
  localparam int unsigned F  = PARAM_FRAC_BITS;
  localparam int unsigned NB = T_INT_BITS + F;
  localparam int unsigned TW = NB + 1;

  // magnitudes and signs
  logic [D-1:0] ad_q, av_q;
  logic         neg_a_q, dpos_a_q, dneg_a_q;
  logic [D-1:0] ad_d, av_d;

  assign ad_d = dist_i[D-1] ? D'(-dist_i) : D'(dist_i);
  assign av_d = dir_i[D-1]  ? D'(-dir_i)  : D'(dir_i);

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      ad_q     <= ad_d;
      av_q     <= av_d;
      neg_a_q  <= dist_i[D-1] != dir_i[D-1];
      dpos_a_q <= !dist_i[D-1] && (dist_i != '0);
      dneg_a_q <= dist_i[D-1];
    end
  end

  // divider state, index 0 is the set-up stage
  logic [D-1:0]  r_q  [0:NB];
  logic [D-1:0]  dv_q [0:NB];
  logic [NB-1:0] nb_q [0:NB];
  logic [NB-1:0] qt_q [0:NB];
  slab_flags_t   fl_q [0:NB];

  // range check and first partial remainder
  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      r_q[0]       <= D'(ad_q >> T_INT_BITS);
      nb_q[0]      <= {ad_q[T_INT_BITS-1:0], {F{1'b0}}};
      qt_q[0]      <= '0;
      dv_q[0]      <= av_q;
      fl_q[0].par  <= av_q <= D'(limit_i);
      fl_q[0].sat  <= {{T_INT_BITS{1'b0}}, ad_q} >= {av_q, {T_INT_BITS{1'b0}}};
      fl_q[0].neg  <= neg_a_q;
      fl_q[0].dpos <= dpos_a_q;
      fl_q[0].dneg <= dneg_a_q;
    end
  end

  // one quotient bit per stage
  for (genvar j = 1; j <= NB; j++) begin : g_step
    logic [D:0] r2, diff;
    logic       ge;
    always_comb begin
      r2   = {r_q[j-1], nb_q[j-1][NB-1]};
      diff = r2 - {1'b0, dv_q[j-1]};
      ge   = r2 >= {1'b0, dv_q[j-1]};
    end
    always_ff @(posedge clk_i) begin
      if (ld_i[j+1]) begin
        r_q[j]  <= ge ? diff[D-1:0] : r2[D-1:0];
        nb_q[j] <= nb_q[j-1] << 1;
        qt_q[j] <= {qt_q[j-1][NB-2:0], ge};
        dv_q[j] <= dv_q[j-1];
        fl_q[j] <= fl_q[j-1];
      end
    end
  end

  // saturation, parallel case and sign
  localparam logic [TW-1:0] T_LIMIT = {1'b0, {NB{1'b1}}};
  logic [TW-1:0] mag, t_d;
  logic [TW-1:0] t_q;

  always_comb begin
    mag = fl_q[NB].sat ? T_LIMIT : {1'b0, qt_q[NB]};
    if (fl_q[NB].par) begin
      if (fl_q[NB].dpos) begin
        t_d = T_LIMIT;
      end else if (fl_q[NB].dneg) begin
        t_d = -T_LIMIT;
      end else begin
        t_d = '0;
      end
    end else begin
      t_d = fl_q[NB].neg ? -mag : mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[NB+2]) begin
      t_q <= t_d;
    end
  end

  assign t_o = $signed(t_q);

endmodule
`default_nettype wire
